@@ hw/rtl/tcprx_pkg.sv @@
// shared types, codes and sequence compare helpers for the tcp receive engine
package tcprx_pkg;

    // connection states
    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_RECV    = 4'd2,
        ST_SYN_SENT    = 4'd3,
        ST_ESTAB       = 4'd4,
        ST_CLOSE_WAIT  = 4'd5,
        ST_LAST_ACK    = 4'd6,
        ST_FIN_WAIT_1  = 4'd7,
        ST_FIN_WAIT_2  = 4'd8,
        ST_CLOSING     = 4'd9,
        ST_TIME_WAIT   = 4'd10
    } t_conn_state;

    // reply codes
    typedef enum logic [1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_RST    = 2'd1,
        REPLY_ACK    = 2'd2,
        REPLY_SYNACK = 2'd3
    } t_reply;

    // timer actions
    typedef enum logic [1:0] {
        TMR_NONE     = 2'd0,
        TMR_RETX     = 2'd1,
        TMR_TW_START = 2'd2,
        TMR_TW_RESET = 2'd3
    } t_timer;

    // item kinds
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    // segment flag bit positions
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 4;

    // wake-up bits
    localparam logic [4:0] WAKE_CONNECT = 5'b00001;
    localparam logic [4:0] WAKE_SEND    = 5'b00010;
    localparam logic [4:0] WAKE_RECV    = 5'b00100;
    localparam logic [4:0] WAKE_ACCEPT  = 5'b01000;
    localparam logic [4:0] WAKE_ENQUEUE = 5'b10000;

    // one input transaction
    typedef struct packed {
        logic        kind;
        logic [5:0]  flags;
        logic [31:0] seq;
        logic [31:0] seq_end;
        logic [31:0] ack_num;
        logic [15:0] window;
        logic [15:0] payload_len;
        logic [31:0] new_iss;
        logic [15:0] buffer_free;
        logic        parent_ready;
        logic [3:0]  load_state;
    } t_item;

    // connection state and sequence variables
    typedef struct packed {
        t_conn_state state;
        logic [31:0] init_seq;
        logic [31:0] send_unacked;
        logic [31:0] send_next;
        logic [31:0] recv_next;
        logic [15:0] recv_window;
        logic [15:0] send_window;
    } t_vars;

    // one result transaction
    typedef struct packed {
        t_reply      reply;
        t_conn_state state_after;
        logic [4:0]  wake_mask;
        logic [15:0] bytes_taken;
        logic [15:0] bytes_trimmed;
        t_timer      timer_action;
        logic        release_res;
        logic        child_spawn;
    } t_result;

    // wrap-around sequence compare: a before b
    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    // wrap-around sequence compare: a before or equal to b
    function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
        return (a == b) || seq_lt(a, b);
    endfunction

endpackage

@@ hw/rtl/tcprx_eval.sv @@
// segment and load evaluation: next connection variables and result fields
module tcprx_eval
    import tcprx_pkg::*;
(
    input  t_item   i_item,
    input  t_vars   i_vars,
    output t_vars   o_vars,
    output t_result o_res
);

    always_comb begin
        logic        f_fin;
        logic        f_syn;
        logic        f_rst;
        logic        f_ack;
        logic        bad_ack;
        logic [31:0] una_v;
        logic [15:0] win_eff;
        logic [31:0] rend;
        logic        in_win;
        logic        stop;
        logic        ack_due;
        logic        ok;
        logic [31:0] s_adj;
        logic [15:0] adv;
        logic [15:0] len;
        logic [31:0] diff;
        t_conn_state st;

        f_fin    = i_item.flags[FLAG_FIN];
        f_syn    = i_item.flags[FLAG_SYN];
        f_rst    = i_item.flags[FLAG_RST];
        f_ack    = i_item.flags[FLAG_ACK];
        bad_ack  = 1'b0;
        una_v    = i_vars.send_unacked;
        win_eff  = (i_vars.recv_window != 16'd0) ? i_vars.recv_window : 16'd1;
        rend     = i_vars.recv_next + {16'd0, win_eff};
        in_win   = seq_lt(i_item.seq, rend) && seq_le(i_vars.recv_next, i_item.seq_end);
        stop     = 1'b0;
        ack_due  = 1'b0;
        ok       = 1'b1;
        s_adj    = i_item.seq;
        adv      = 16'd0;
        len      = i_item.payload_len;
        diff     = 32'd0;
        st       = i_vars.state;

        o_vars = i_vars;
        o_res  = '0;

        if (i_item.kind == KIND_LOAD) begin
            // local load of state and sender variables
            o_vars.state        = (i_item.load_state > ST_TIME_WAIT) ? ST_CLOSED
                                                                     : t_conn_state'(i_item.load_state);
            o_vars.init_seq     = i_item.new_iss;
            o_vars.send_next    = i_item.seq;
            o_vars.send_unacked = i_item.ack_num;
            o_vars.recv_window  = i_item.window;
        end else begin
            case (i_vars.state)
                ST_CLOSED: begin
                    if (!f_rst) o_res.reply = REPLY_RST;
                end
                ST_LISTEN: begin
                    // a clean syn spawns a child, listener stays put
                    if (!f_rst && f_syn) begin
                        if (f_ack) begin
                            o_res.reply = REPLY_RST;
                        end else begin
                            o_res.child_spawn = 1'b1;
                            o_res.reply       = REPLY_SYNACK;
                        end
                    end
                end
                ST_SYN_SENT: begin
                    bad_ack = f_ack && (seq_le(i_item.ack_num, i_vars.init_seq)
                                        || seq_lt(i_vars.send_next, i_item.ack_num));
                    if (bad_ack) begin
                        if (!f_rst) o_res.reply = REPLY_RST;
                    end else if (f_rst) begin
                        o_vars.state    = ST_CLOSED;
                        o_res.wake_mask = WAKE_CONNECT;
                    end else if (f_syn) begin
                        o_vars.recv_next = i_item.seq_end;
                        if (f_ack) una_v = i_item.ack_num;
                        o_vars.send_unacked = una_v;
                        if (seq_lt(i_vars.init_seq, una_v)) begin
                            o_vars.state       = ST_ESTAB;
                            o_vars.send_window = i_item.window;
                            o_res.reply        = REPLY_ACK;
                            o_res.wake_mask    = WAKE_CONNECT;
                        end else begin
                            o_vars.state       = ST_SYN_RECV;
                            o_res.reply        = REPLY_SYNACK;
                            o_res.timer_action = TMR_RETX;
                        end
                    end
                end
                ST_SYN_RECV: begin
                    if (!(seq_le(i_vars.send_unacked, i_item.ack_num)
                          && seq_le(i_item.ack_num, i_vars.send_next))) begin
                        if (!f_rst) o_res.reply = REPLY_RST;
                    end else if (i_item.parent_ready) begin
                        o_vars.send_unacked = i_item.ack_num;
                        o_vars.send_window  = i_item.window;
                        o_vars.state        = ST_ESTAB;
                        o_res.wake_mask     = WAKE_ACCEPT | WAKE_ENQUEUE
                                              | ((i_vars.send_window == 16'd0) ? WAKE_SEND
                                                                               : 5'd0);
                    end
                end
                default: begin
                    // synchronized states
                    if (in_win) begin
                        if (f_rst) begin
                            o_vars.state      = ST_CLOSED;
                            o_res.release_res = 1'b1;
                        end else if (f_syn) begin
                            o_res.reply       = REPLY_RST;
                            o_vars.state      = ST_CLOSED;
                            o_res.release_res = 1'b1;
                        end else if (f_ack) begin
                            // acknowledgment processing
                            if (st == ST_ESTAB || st == ST_CLOSE_WAIT || st == ST_LAST_ACK
                                || st == ST_FIN_WAIT_1 || st == ST_CLOSING) begin
                                if (seq_lt(i_vars.send_unacked, i_item.ack_num)
                                    && seq_le(i_item.ack_num, i_vars.send_next)) begin
                                    una_v               = i_item.ack_num;
                                    o_vars.send_unacked = i_item.ack_num;
                                    if (st == ST_FIN_WAIT_1) begin
                                        st = ST_FIN_WAIT_2;
                                    end else if (st == ST_CLOSING) begin
                                        o_vars.state       = ST_TIME_WAIT;
                                        o_res.timer_action = TMR_TW_START;
                                        stop               = 1'b1;
                                    end else if (st == ST_LAST_ACK) begin
                                        o_vars.state      = ST_CLOSED;
                                        o_res.release_res = 1'b1;
                                        stop              = 1'b1;
                                    end
                                end else if (seq_lt(i_vars.send_next, i_item.ack_num)) begin
                                    stop = 1'b1;
                                end
                                if (!stop && seq_le(una_v, i_item.ack_num)
                                    && seq_le(i_item.ack_num, i_vars.send_next)) begin
                                    if (i_vars.send_window == 16'd0) begin
                                        o_res.wake_mask = o_res.wake_mask | WAKE_SEND;
                                    end
                                    o_vars.send_window = i_item.window;
                                end
                            end

                            if (!stop) begin
                                o_vars.state = st;
                                // payload intake with leading overlap trim
                                if ((st == ST_ESTAB || st == ST_FIN_WAIT_1
                                     || st == ST_FIN_WAIT_2)
                                    && i_item.payload_len != 16'd0
                                    && i_vars.recv_window != 16'd0) begin
                                    if (seq_lt(i_item.seq, i_vars.recv_next)) begin
                                        if (seq_le(i_item.seq + {16'd0, i_item.payload_len},
                                                   i_vars.recv_next)) begin
                                            ok = 1'b0;
                                        end else begin
                                            diff                = i_vars.recv_next - i_item.seq;
                                            adv                 = diff[15:0];
                                            s_adj               = i_item.seq + {16'd0, adv};
                                            len                 = i_item.payload_len - adv;
                                            o_res.bytes_trimmed = adv;
                                        end
                                    end
                                    if (ok) begin
                                        if (i_vars.recv_next == s_adj
                                            && i_item.buffer_free >= len) begin
                                            o_res.bytes_taken  = len;
                                            o_vars.recv_window = (i_vars.recv_window >= len)
                                                                 ? i_vars.recv_window - len
                                                                 : 16'd0;
                                            o_res.wake_mask    = o_res.wake_mask | WAKE_RECV;
                                        end
                                        ack_due = 1'b1;
                                    end
                                end

                                // fin handling
                                if (f_fin) begin
                                    case (st)
                                        ST_ESTAB: begin
                                            o_vars.state    = ST_CLOSE_WAIT;
                                            o_res.wake_mask = o_res.wake_mask | WAKE_RECV;
                                        end
                                        ST_FIN_WAIT_1: begin
                                            o_vars.state = ST_CLOSING;
                                        end
                                        ST_TIME_WAIT: begin
                                            o_res.timer_action = TMR_TW_RESET;
                                        end
                                        ST_FIN_WAIT_2: begin
                                            o_vars.state       = ST_TIME_WAIT;
                                            o_res.timer_action = TMR_TW_START;
                                        end
                                        default: begin
                                        end
                                    endcase
                                    ack_due = 1'b1;
                                end
                                o_vars.recv_next = i_item.seq_end;
                                if (ack_due) o_res.reply = REPLY_ACK;
                            end
                        end
                    end
                end
            endcase
        end

        o_res.state_after = o_vars.state;
    end

endmodule

@@ hw/rtl/tcp_receive_state_machine.sv @@
// top level of the tcp receive engine: input register, state, result register
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_ready   kind, flags, seq .. load_state
//  output   out        o_out_valid / i_out_ready reply, state_after .. child_spawn
//
// one transaction per cycle while the output is not stalled; an accepted item
// enters the input register, which feeds one pass of evaluation that updates
// the connection variables and fills the result register in the same cycle
// reset clears the connection to closed with all sequence variables zero
// a stalled output holds its result and the input register, the input side keeps
// accepting as long as the input register moves on
module tcp_receive_state_machine
    import tcprx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [5:0]  i_flags,
    input  logic [31:0] i_seq,
    input  logic [31:0] i_seq_end,
    input  logic [31:0] i_ack_num,
    input  logic [15:0] i_window,
    input  logic [15:0] i_payload_len,
    input  logic [31:0] i_new_iss,
    input  logic [15:0] i_buffer_free,
    input  logic        i_parent_ready,
    input  logic [3:0]  i_load_state,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_reply,
    output logic [3:0]  o_state_after,
    output logic [4:0]  o_wake_mask,
    output logic [15:0] o_bytes_taken,
    output logic [15:0] o_bytes_trimmed,
    output logic [1:0]  o_timer_action,
    output logic        o_release_res,
    output logic        o_child_spawn
);

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;
    t_vars   r_vars;
    t_vars   n_vars;
    t_result n_res;
    logic    w_step;

    // evaluation fires when the result register is free or draining
    assign w_step     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_step;

    tcprx_eval u_eval (
        .i_item (r_item),
        .i_vars (r_vars),
        .o_vars (n_vars),
        .o_res  (n_res)
    );

    // control and connection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_vars    <= '{state: ST_CLOSED, default: '0};
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            if (w_step) begin
                r_out_vld <= 1'b1;
                r_vars    <= n_vars;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{kind: i_kind, flags: i_flags, seq: i_seq, seq_end: i_seq_end,
                        ack_num: i_ack_num, window: i_window, payload_len: i_payload_len,
                        new_iss: i_new_iss, buffer_free: i_buffer_free,
                        parent_ready: i_parent_ready, load_state: i_load_state};
        end
        if (w_step) r_res <= n_res;
    end

    // result outputs
    assign o_out_valid     = r_out_vld;
    assign o_reply         = r_res.reply;
    assign o_state_after   = r_res.state_after;
    assign o_wake_mask     = r_res.wake_mask;
    assign o_bytes_taken   = r_res.bytes_taken;
    assign o_bytes_trimmed = r_res.bytes_trimmed;
    assign o_timer_action  = r_res.timer_action;
    assign o_release_res   = r_res.release_res;
    assign o_child_spawn   = r_res.child_spawn;

`ifndef SYNTHESIS
    // connection variables move only on an evaluation step
    a_vars_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_vars))
        else $error("connection variables changed without a step");

    // every step leaves a result pending
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_vld)
        else $error("step did not produce a result");

    // a spawned child leaves the listener in place with a syn-ack
    a_child_listen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.child_spawn)
            |-> (r_res.state_after == ST_LISTEN && r_res.reply == REPLY_SYNACK))
        else $error("child spawn outside listen");

    // release always ends in closed
    a_release_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.release_res) |-> (r_res.state_after == ST_CLOSED))
        else $error("release without closed state");

    // taken bytes are acknowledged and wake the receiver
    a_taken_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.bytes_taken != 16'd0)
            |-> (r_res.reply == REPLY_ACK && r_res.wake_mask[2]))
        else $error("payload taken without ack or wake");
`endif

endmodule

@@ sim/tcp_receive_state_machine_tb.sv @@
// self-checking testbench for the tcp receive engine: directed and random segments and loads
module tcp_receive_state_machine_tb;
    import tcprx_pkg::*;

    // segment flag masks built from the package bit positions
    localparam logic [5:0] FL_FIN = 6'(1 << FLAG_FIN);
    localparam logic [5:0] FL_SYN = 6'(1 << FLAG_SYN);
    localparam logic [5:0] FL_RST = 6'(1 << FLAG_RST);
    localparam logic [5:0] FL_ACK = 6'(1 << FLAG_ACK);
    localparam logic [5:0] FL_PSH = 6'b001000;

    localparam int RANDOM_ITEMS = 1700;
    localparam int LIMIT_CYCLES = 400000;

    // tracks one connection's state and the results owed for accepted transactions
    class conn_scoreboard;
        t_vars       conn;
        t_result     pending_results[$];
        int          mismatches;
        int          results_checked;
        int          loads_noted;
        int          segments_noted;
        longint      bytes_taken_total;
        logic [15:0] states_reached;

        function new();
            conn = '0;
            conn.state = ST_CLOSED;
            mismatches = 0;
            results_checked = 0;
            loads_noted = 0;
            segments_noted = 0;
            bytes_taken_total = 0;
            states_reached = 16'h0001;
        endfunction

        // a older than b in 32-bit sequence space
        function bit seq_older(logic [31:0] a, logic [31:0] b);
            logic [31:0] diff;
            diff = a - b;
            return diff[31];
        endfunction

        function bit seq_no_later(logic [31:0] a, logic [31:0] b);
            return (a == b) || seq_older(a, b);
        endfunction

        // outcome of one segment or load; state_after is filled by the caller
        function t_result segment_outcome(t_item it);
            t_result     r;
            t_conn_state st;
            logic        rst;
            logic        ack_due;
            logic [31:0] span;
            logic [31:0] s;
            logic [15:0] len;
            logic [15:0] adv;
            logic        ok;
            r = '0;
            rst = it.flags[FLAG_RST];
            ack_due = 1'b0;
            st = conn.state;

            // local load of state and sender variables
            if (it.kind == KIND_LOAD) begin
                conn.state = (it.load_state > ST_TIME_WAIT) ? ST_CLOSED
                                                            : t_conn_state'(it.load_state);
                conn.init_seq = it.new_iss;
                conn.send_next = it.seq;
                conn.send_unacked = it.ack_num;
                conn.recv_window = it.window;
                return r;
            end

            // closed: answer anything but a reset with a reset
            if (st == ST_CLOSED) begin
                if (!rst) r.reply = REPLY_RST;
                return r;
            end

            // listen: a bare syn spawns a child, the listener stays
            if (st == ST_LISTEN) begin
                if (rst || !it.flags[FLAG_SYN]) return r;
                if (it.flags[FLAG_ACK]) begin
                    r.reply = REPLY_RST;
                    return r;
                end
                r.child_spawn = 1'b1;
                r.reply = REPLY_SYNACK;
                return r;
            end

            // syn sent: check the ack against what was sent
            if (st == ST_SYN_SENT) begin
                if (it.flags[FLAG_ACK] && (seq_no_later(it.ack_num, conn.init_seq) ||
                                           seq_older(conn.send_next, it.ack_num))) begin
                    if (!rst) r.reply = REPLY_RST;
                    return r;
                end
                if (rst) begin
                    conn.state = ST_CLOSED;
                    r.wake_mask |= WAKE_CONNECT;
                    return r;
                end
                if (it.flags[FLAG_SYN]) begin
                    conn.recv_next = it.seq_end;
                    if (it.flags[FLAG_ACK]) conn.send_unacked = it.ack_num;
                    if (seq_older(conn.init_seq, conn.send_unacked)) begin
                        conn.state = ST_ESTAB;
                        conn.send_window = it.window;
                        r.reply = REPLY_ACK;
                        r.wake_mask |= WAKE_CONNECT;
                    end else begin
                        conn.state = ST_SYN_RECV;
                        r.reply = REPLY_SYNACK;
                        r.timer_action = TMR_RETX;
                    end
                end
                return r;
            end

            // syn received: acceptable ack completes the handshake if the parent has room
            if (st == ST_SYN_RECV) begin
                if (!(seq_no_later(conn.send_unacked, it.ack_num) &&
                      seq_no_later(it.ack_num, conn.send_next))) begin
                    if (!rst) r.reply = REPLY_RST;
                    return r;
                end
                if (!it.parent_ready) return r;
                conn.send_unacked = it.ack_num;
                if (conn.send_window == 16'd0) r.wake_mask |= WAKE_SEND;
                conn.send_window = it.window;
                conn.state = ST_ESTAB;
                r.wake_mask |= WAKE_ACCEPT | WAKE_ENQUEUE;
                return r;
            end

            // synchronized states: receive window test
            span = (conn.recv_window != 16'd0) ? {16'd0, conn.recv_window} : 32'd1;
            if (!(seq_older(it.seq, conn.recv_next + span) &&
                  seq_no_later(conn.recv_next, it.seq_end))) return r;
            if (rst) begin
                conn.state = ST_CLOSED;
                r.release_res = 1'b1;
                return r;
            end
            if (it.flags[FLAG_SYN]) begin
                r.reply = REPLY_RST;
                conn.state = ST_CLOSED;
                r.release_res = 1'b1;
                return r;
            end
            if (!it.flags[FLAG_ACK]) return r;

            // ack processing
            if (st inside {ST_ESTAB, ST_CLOSE_WAIT, ST_LAST_ACK, ST_FIN_WAIT_1, ST_CLOSING}) begin
                if (seq_older(conn.send_unacked, it.ack_num) &&
                    seq_no_later(it.ack_num, conn.send_next)) begin
                    conn.send_unacked = it.ack_num;
                    if (st == ST_FIN_WAIT_1) begin
                        conn.state = ST_FIN_WAIT_2;
                    end else if (st == ST_CLOSING) begin
                        conn.state = ST_TIME_WAIT;
                        r.timer_action = TMR_TW_START;
                        return r;
                    end else if (st == ST_LAST_ACK) begin
                        conn.state = ST_CLOSED;
                        r.release_res = 1'b1;
                        return r;
                    end
                end else if (seq_older(conn.send_next, it.ack_num)) begin
                    return r;
                end
                if (seq_no_later(conn.send_unacked, it.ack_num) &&
                    seq_no_later(it.ack_num, conn.send_next)) begin
                    if (conn.send_window == 16'd0) r.wake_mask |= WAKE_SEND;
                    conn.send_window = it.window;
                end
            end

            // payload: trim old bytes, take in-order data that fits
            st = conn.state;
            if (st inside {ST_ESTAB, ST_FIN_WAIT_1, ST_FIN_WAIT_2} && it.payload_len != 16'd0 &&
                conn.recv_window != 16'd0) begin
                s = it.seq;
                len = it.payload_len;
                ok = 1'b1;
                if (seq_older(s, conn.recv_next)) begin
                    if (seq_no_later(s + {16'd0, len}, conn.recv_next)) begin
                        ok = 1'b0;
                    end else begin
                        adv = 16'(conn.recv_next - s);
                        s = s + {16'd0, adv};
                        len = len - adv;
                        r.bytes_trimmed = adv;
                    end
                end
                if (ok) begin
                    if (conn.recv_next == s && it.buffer_free >= len) begin
                        r.bytes_taken = len;
                        conn.recv_next = conn.recv_next + {16'd0, len};
                        conn.recv_window = (conn.recv_window >= len) ? conn.recv_window - len : 16'd0;
                        r.wake_mask |= WAKE_RECV;
                    end
                    ack_due = 1'b1;
                end
            end

            // fin handling by state
            if (it.flags[FLAG_FIN]) begin
                case (st)
                    ST_ESTAB: begin
                        conn.state = ST_CLOSE_WAIT;
                        r.wake_mask |= WAKE_RECV;
                    end
                    ST_FIN_WAIT_1: conn.state = ST_CLOSING;
                    ST_TIME_WAIT: r.timer_action = TMR_TW_RESET;
                    ST_FIN_WAIT_2: begin
                        conn.state = ST_TIME_WAIT;
                        r.timer_action = TMR_TW_START;
                    end
                    default: ;
                endcase
                ack_due = 1'b1;
            end
            conn.recv_next = it.seq_end;
            if (ack_due) r.reply = REPLY_ACK;
            return r;
        endfunction

        // accepted input transaction: queue its result
        function void note_input(t_item it);
            t_result r;
            r = segment_outcome(it);
            r.state_after = conn.state;
            pending_results.push_back(r);
            states_reached[conn.state] = 1'b1;
            if (it.kind == KIND_LOAD) loads_noted++;
            else segments_noted++;
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        // accepted output transaction against the oldest queued result
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual reply %0d state %0d",
                         $time, got.reply, got.state_after);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("reply", want.reply, got.reply);
            compare_field("state_after", want.state_after, got.state_after);
            compare_field("wake_mask", want.wake_mask, got.wake_mask);
            compare_field("bytes_taken", want.bytes_taken, got.bytes_taken);
            compare_field("bytes_trimmed", want.bytes_trimmed, got.bytes_trimmed);
            compare_field("timer_action", want.timer_action, got.timer_action);
            compare_field("release_res", want.release_res, got.release_res);
            compare_field("child_spawn", want.child_spawn, got.child_spawn);
            bytes_taken_total += got.bytes_taken;
            results_checked++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = 1'b0;
    logic [5:0]  i_flags = '0;
    logic [31:0] i_seq = '0;
    logic [31:0] i_seq_end = '0;
    logic [31:0] i_ack_num = '0;
    logic [15:0] i_window = '0;
    logic [15:0] i_payload_len = '0;
    logic [31:0] i_new_iss = '0;
    logic [15:0] i_buffer_free = '0;
    logic        i_parent_ready = 1'b0;
    logic [3:0]  i_load_state = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_reply;
    logic [3:0]  o_state_after;
    logic [4:0]  o_wake_mask;
    logic [15:0] o_bytes_taken;
    logic [15:0] o_bytes_trimmed;
    logic [1:0]  o_timer_action;
    logic        o_release_res;
    logic        o_child_spawn;

    conn_scoreboard sb;
    logic           steady = 1'b0;
    t_result        observed;

    tcp_receive_state_machine u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_flags         (i_flags),
        .i_seq           (i_seq),
        .i_seq_end       (i_seq_end),
        .i_ack_num       (i_ack_num),
        .i_window        (i_window),
        .i_payload_len   (i_payload_len),
        .i_new_iss       (i_new_iss),
        .i_buffer_free   (i_buffer_free),
        .i_parent_ready  (i_parent_ready),
        .i_load_state    (i_load_state),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_reply         (o_reply),
        .o_state_after   (o_state_after),
        .o_wake_mask     (o_wake_mask),
        .o_bytes_taken   (o_bytes_taken),
        .o_bytes_trimmed (o_bytes_trimmed),
        .o_timer_action  (o_timer_action),
        .o_release_res   (o_release_res),
        .o_child_spawn   (o_child_spawn)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 14);
    end

    // result transaction check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready && sb != null) begin
            observed.reply         = t_reply'(o_reply);
            observed.state_after   = t_conn_state'(o_state_after);
            observed.wake_mask     = o_wake_mask;
            observed.bytes_taken   = o_bytes_taken;
            observed.bytes_trimmed = o_bytes_trimmed;
            observed.timer_action  = t_timer'(o_timer_action);
            observed.release_res   = o_release_res;
            observed.child_spawn   = o_child_spawn;
            sb.check_result(observed);
        end
    end

    // present one input transaction from a falling edge and hold it until accepted
    task automatic drive_item(input t_item it);
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_kind         <= it.kind;
        i_flags        <= it.flags;
        i_seq          <= it.seq;
        i_seq_end      <= it.seq_end;
        i_ack_num      <= it.ack_num;
        i_window       <= it.window;
        i_payload_len  <= it.payload_len;
        i_new_iss      <= it.new_iss;
        i_buffer_free  <= it.buffer_free;
        i_parent_ready <= it.parent_ready;
        i_load_state   <= it.load_state;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic send_seg(input logic [5:0] fl, input logic [31:0] sq, input logic [31:0] se,
                            input logic [31:0] ak, input logic [15:0] wn, input logic [15:0] pl,
                            input logic [15:0] bf, input logic pr);
        t_item it;
        it = '0;
        it.kind = KIND_SEGMENT;
        it.flags = fl;
        it.seq = sq;
        it.seq_end = se;
        it.ack_num = ak;
        it.window = wn;
        it.payload_len = pl;
        it.buffer_free = bf;
        it.parent_ready = pr;
        drive_item(it);
    endtask

    task automatic send_load(input t_conn_state st, input logic [31:0] iss,
                             input logic [31:0] nxt, input logic [31:0] una,
                             input logic [15:0] wn);
        t_item it;
        it = '0;
        it.kind = KIND_LOAD;
        it.load_state = st;
        it.new_iss = iss;
        it.seq = nxt;
        it.ack_num = una;
        it.window = wn;
        drive_item(it);
    endtask

    // 16-bit value leaning toward zero, full scale and small sizes
    function automatic logic [15:0] rand_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return 16'd0;
        if (roll < 30) return 16'hFFFF;
        if (roll < 70) return 16'($urandom_range(1, 200));
        return 16'($urandom_range(0, 65535));
    endfunction

    // random transaction shaped by the current connection state
    function automatic t_item random_item();
        t_item       it;
        t_vars       c;
        int          roll;
        int          syn_pct;
        logic [31:0] base;
        c = sb.conn;
        it = '0;
        roll = $urandom_range(0, 99);

        // local load, more often when the connection sits closed
        if (roll < 6 || (c.state == ST_CLOSED && roll < 45)) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) base = 32'hFFFF_FF80 + $urandom_range(0, 255);
            else if (roll < 75) base = $urandom_range(0, 5000);
            else base = $urandom();
            it.kind = KIND_LOAD;
            it.load_state = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                        : 4'($urandom_range(0, 10));
            it.ack_num = base;
            it.seq = base + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
            it.new_iss = base - $urandom_range(0, 2);
            it.window = rand_size();
            it.flags = 6'($urandom());
            it.seq_end = $urandom();
            it.payload_len = 16'($urandom());
            it.buffer_free = 16'($urandom());
            it.parent_ready = 1'($urandom());
            return it;
        end

        // segment flags
        it.kind = KIND_SEGMENT;
        syn_pct = (c.state inside {ST_LISTEN, ST_SYN_SENT}) ? 55 : 5;
        it.flags[FLAG_ACK] = ($urandom_range(0, 99) < 80);
        it.flags[FLAG_SYN] = ($urandom_range(0, 99) < syn_pct);
        it.flags[FLAG_RST] = ($urandom_range(0, 99) < 5);
        it.flags[FLAG_FIN] = ($urandom_range(0, 99) < 15);
        it.flags[3] = 1'($urandom());
        it.flags[5] = 1'($urandom());

        // payload size, mostly small
        roll = $urandom_range(0, 99);
        if (roll < 30) it.payload_len = 16'd0;
        else if (roll < 90) it.payload_len = 16'($urandom_range(1, 40));
        else it.payload_len = 16'($urandom());

        // sequence near the receive point, some behind for trimming
        roll = $urandom_range(0, 99);
        if (roll < 70) it.seq = c.recv_next + $urandom_range(0, 2);
        else if (roll < 85) it.seq = c.recv_next - $urandom_range(1, 30);
        else if (roll < 95) it.seq = c.recv_next + $urandom_range(3, 300);
        else it.seq = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 85) it.seq_end = it.seq + it.payload_len + it.flags[FLAG_SYN] + it.flags[FLAG_FIN];
        else if (roll < 92) it.seq_end = it.seq - 1;
        else it.seq_end = $urandom();

        // acknowledgment around the unacked and next points
        roll = $urandom_range(0, 99);
        if (roll < 35) it.ack_num = c.send_next;
        else if (roll < 55) it.ack_num = c.send_unacked;
        else if (roll < 70) it.ack_num = c.send_unacked + $urandom_range(0, 8);
        else if (roll < 80) it.ack_num = c.send_next + 1;
        else if (roll < 88) it.ack_num = c.send_unacked - 1;
        else if (roll < 94) it.ack_num = c.init_seq + 1;
        else it.ack_num = $urandom();

        it.window = rand_size();
        it.buffer_free = ($urandom_range(0, 99) < 80) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 40));
        it.parent_ready = ($urandom_range(0, 99) < 85);
        it.new_iss = $urandom();
        it.load_state = 4'($urandom());
        return it;
    endfunction

    // run limit
    initial begin
        #(12 * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_item it;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // closed answers with reset, except to a reset
        send_seg(FL_ACK, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        it = '1;
        it.kind = KIND_SEGMENT;
        drive_item(it);

        // listen: reset ignored, syn with ack refused, bare syn spawns a child
        send_load(ST_LISTEN, 32'd10, 32'd11, 32'd10, 16'd100);
        send_seg(FL_RST | FL_SYN, 32'd7, 32'd8, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_seg(FL_SYN | FL_ACK, 32'd7, 32'd8, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_seg(FL_SYN, 32'd7, 32'd8, 32'd0, 16'd9, 16'd0, 16'd0, 1'b1);

        // load of an out-of-range state, all fields at full scale
        it = '1;
        it.kind = KIND_LOAD;
        drive_item(it);

        // active open through syn sent
        send_load(ST_SYN_SENT, 32'd100, 32'd101, 32'd100, 16'd1000);
        send_seg(FL_ACK, 32'd5000, 32'd5001, 32'd100, 16'd0, 16'd0, 16'd0, 1'b1);
        send_seg(FL_SYN | FL_ACK, 32'd5000, 32'd5001, 32'd101, 16'd0, 16'd0, 16'd0, 1'b1);

        // established data: in order, overlapping, no buffer room
        send_seg(FL_ACK | FL_PSH, sb.conn.recv_next, sb.conn.recv_next + 10, 32'd101,
                 16'd2000, 16'd10, 16'hFFFF, 1'b1);
        send_seg(FL_ACK, sb.conn.recv_next - 5, sb.conn.recv_next + 10, 32'd101,
                 16'd2000, 16'd15, 16'hFFFF, 1'b1);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 10, 32'd101,
                 16'd2000, 16'd10, 16'd3, 1'b1);

        // receive window shrinks past zero and saturates
        send_load(ST_ESTAB, 32'd100, 32'd101, 32'd101, 16'd4);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 10, 32'd101,
                 16'd2000, 16'd10, 16'hFFFF, 1'b1);
        send_seg(FL_FIN | FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 1, 32'd101,
                 16'd2000, 16'd0, 16'hFFFF, 1'b1);

        // fin in fin_wait_2 starts timewait, another fin resets it, reset closes
        send_load(ST_FIN_WAIT_2, 32'd100, 32'd101, 32'd101, 16'd100);
        send_seg(FL_FIN | FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 1, 32'd101,
                 16'd50, 16'd0, 16'hFFFF, 1'b1);
        send_seg(FL_FIN | FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 1, 32'd101,
                 16'd50, 16'd0, 16'hFFFF, 1'b1);
        send_seg(FL_RST, sb.conn.recv_next, sb.conn.recv_next, 32'd0,
                 16'd0, 16'd0, 16'd0, 1'b1);

        // syn received: parent busy drops the segment, then the handshake completes
        send_load(ST_SYN_RECV, 32'd200, 32'd201, 32'd201, 16'd100);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next, 32'd201,
                 16'd500, 16'd0, 16'd0, 1'b0);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next, 32'd201,
                 16'd500, 16'd0, 16'd0, 1'b1);
        send_seg(FL_SYN, sb.conn.recv_next, sb.conn.recv_next + 1, 32'd201,
                 16'd500, 16'd0, 16'd0, 1'b1);

        // closing states advanced by an ack
        send_load(ST_FIN_WAIT_1, 32'd299, 32'd301, 32'd300, 16'd100);
        send_seg(FL_FIN | FL_ACK, sb.conn.recv_next, sb.conn.recv_next + 1, 32'd301,
                 16'd100, 16'd0, 16'd0, 1'b1);
        send_load(ST_CLOSING, 32'd299, 32'd301, 32'd300, 16'd100);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next, 32'd301,
                 16'd100, 16'd0, 16'd0, 1'b1);
        send_load(ST_LAST_ACK, 32'd299, 32'd301, 32'd300, 16'd100);
        send_seg(FL_ACK, sb.conn.recv_next, sb.conn.recv_next, 32'd301,
                 16'd100, 16'd0, 16'd0, 1'b1);

        // random traffic, with a stretch of full throughput in the middle
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1000);
            drive_item(random_item());
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d segments and %0d local loads, %0d results checked",
                 sb.segments_noted, sb.loads_noted, sb.results_checked);
        $display("%0d of 11 connection states reached, %0d payload bytes taken",
                 $countones(sb.states_reached), sb.bytes_taken_total);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/tcprx_pkg.sv
hw/rtl/tcprx_eval.sv
hw/rtl/tcp_receive_state_machine.sv
sim/tcp_receive_state_machine_tb.sv
